// ----- sv/tlbfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfl_pkg
// Shared types and constants of the fully associative translation buffer.
// ----------------------------------------------------------------------------
package tlbfl_pkg;

    localparam int COUNT_BITS = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // register index of the replacement policy
    localparam logic REG_POLICY_LRU = 1'b0;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load_in;
        logic commit;
    } t_cmd;

endpackage

// ----- sv/tlbfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfl_ctrl
// Sequencer: takes a request, runs its lookup/update in the execute state,
// owns the output-valid flag.
// ----------------------------------------------------------------------------
module tlbfl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tlbfl_pkg::t_cmd  o_cmd
);

    tlbfl_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    // output register can take a result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlbfl_pkg::S_IDLE: begin
                if (i_in_valid) n_state = tlbfl_pkg::S_EXEC;
            end
            tlbfl_pkg::S_EXEC: begin
                if (out_free) n_state = tlbfl_pkg::S_IDLE;
            end
            default: n_state = tlbfl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load_in = 1'b0;
        o_cmd.commit  = 1'b0;
        o_in_stall    = 1'b1;
        n_out_valid   = r_out_valid && i_out_stall;
        case (r_state)
            tlbfl_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            tlbfl_pkg::S_EXEC: begin
                o_cmd.commit = out_free;
                if (out_free) n_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlbfl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/tlbfl_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbfl_dp
// Entry array with parallel page compare, age ranks, counters and the
// result register.
// ----------------------------------------------------------------------------
module tlbfl_dp #(
    parameter int TLB_ENTRIES = 32,
    parameter int PAGE_BITS   = 8,
    parameter int FRAME_BITS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tlbfl_pkg::t_cmd                  i_cmd,
    input  logic                             i_policy_lru,
    input  logic [PAGE_BITS-1:0]             i_page,
    input  logic [FRAME_BITS-1:0]            i_fill_frame,
    output logic [FRAME_BITS-1:0]            o_frame,
    output logic                             o_hit,
    output logic [tlbfl_pkg::COUNT_BITS-1:0] o_lookup_count,
    output logic [tlbfl_pkg::COUNT_BITS-1:0] o_hit_count
);

    localparam int RANK_BITS = $clog2(TLB_ENTRIES);
    localparam int OCC_BITS  = $clog2(TLB_ENTRIES + 1);
    localparam logic [RANK_BITS-1:0] RANK_OLDEST = RANK_BITS'(TLB_ENTRIES - 1);
    localparam logic [OCC_BITS-1:0]  OCC_FULL    = OCC_BITS'(TLB_ENTRIES);

    logic [PAGE_BITS-1:0]  r_page;
    logic [FRAME_BITS-1:0] r_fill;

    logic [TLB_ENTRIES-1:0] r_valid, n_valid;
    logic [PAGE_BITS-1:0]   r_pg   [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]   n_pg   [TLB_ENTRIES];
    logic [FRAME_BITS-1:0]  r_fr   [TLB_ENTRIES];
    logic [FRAME_BITS-1:0]  n_fr   [TLB_ENTRIES];
    logic [RANK_BITS-1:0]   r_rank [TLB_ENTRIES];
    logic [RANK_BITS-1:0]   n_rank [TLB_ENTRIES];
    logic [OCC_BITS-1:0]    r_occ, n_occ;

    logic [tlbfl_pkg::COUNT_BITS-1:0] r_lookups, n_lookups;
    logic [tlbfl_pkg::COUNT_BITS-1:0] r_hits, n_hits;

    logic [FRAME_BITS-1:0] r_out_frame;
    logic                  r_out_hit;

    logic [TLB_ENTRIES-1:0] hit_vec;
    logic [TLB_ENTRIES-1:0] free_vec;
    logic [TLB_ENTRIES-1:0] free_oh;
    logic [TLB_ENTRIES-1:0] victim_oh;
    logic [TLB_ENTRIES-1:0] slot_oh;
    logic                   any_hit;
    logic                   full;
    logic [RANK_BITS-1:0]   match_rank;
    logic [FRAME_BITS-1:0]  match_frame;

    // compare every entry at once; valid pages are unique
    always_comb begin
        match_rank  = '0;
        match_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            hit_vec[i]   = r_valid[i] && (r_pg[i] == r_page);
            victim_oh[i] = r_valid[i] && (r_rank[i] == RANK_OLDEST);
            match_rank   = match_rank  | (hit_vec[i] ? r_rank[i] : '0);
            match_frame  = match_frame | (hit_vec[i] ? r_fr[i]   : '0);
        end
    end

    assign any_hit  = |hit_vec;
    assign full     = (r_occ == OCC_FULL);
    assign free_vec = ~r_valid;
    assign free_oh  = free_vec & (~free_vec + TLB_ENTRIES'(1));
    assign slot_oh  = full ? victim_oh : free_oh;

    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            n_pg[i]   = r_pg[i];
            n_fr[i]   = r_fr[i];
            n_rank[i] = r_rank[i];
            if (any_hit) begin
                if (i_policy_lru) begin
                    if (hit_vec[i]) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && (r_rank[i] < match_rank)) begin
                        n_rank[i] = r_rank[i] + RANK_BITS'(1);
                    end
                end
            end else if (slot_oh[i]) begin
                // install as newest, evicting the oldest when full
                n_valid[i] = 1'b1;
                n_pg[i]    = r_page;
                n_fr[i]    = r_fill;
                n_rank[i]  = '0;
            end else if (r_valid[i]) begin
                n_rank[i] = r_rank[i] + RANK_BITS'(1);
            end
        end
        n_occ     = (!any_hit && !full) ? r_occ + OCC_BITS'(1) : r_occ;
        n_lookups = r_lookups + tlbfl_pkg::COUNT_BITS'(1);
        n_hits    = r_hits + tlbfl_pkg::COUNT_BITS'(any_hit);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_page <= i_page;
            r_fill <= i_fill_frame;
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_pg[i]   <= n_pg[i];
                r_fr[i]   <= n_fr[i];
                r_rank[i] <= n_rank[i];
            end
            r_out_frame <= any_hit ? match_frame : r_fill;
            r_out_hit   <= any_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_occ     <= '0;
            r_lookups <= '0;
            r_hits    <= '0;
        end else if (i_cmd.commit) begin
            r_valid   <= n_valid;
            r_occ     <= n_occ;
            r_lookups <= n_lookups;
            r_hits    <= n_hits;
        end
    end

    assign o_frame        = r_out_frame;
    assign o_hit          = r_out_hit;
    assign o_lookup_count = r_lookups;
    assign o_hit_count    = r_hits;

endmodule

// ----- sv/tlb_fifo_lru_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_fifo_lru_lookup
// Fully associative translation buffer with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries a page number and the
//   frame to install if the page misses. Result channel (o_out_valid /
//   i_out_stall) returns the frame, a hit flag and the running lookup and
//   hit counts, both including this beat and wrapping at 2^32.
//   A request beat is taken in the idle cycle; the next cycle compares the
//   page against every entry in parallel, updates ranks and entries and
//   loads the result register. The two-state sequencer takes no new
//   request until the pending lookup has committed, so that each lookup
//   sees the previous update.
//   A new request is taken while an earlier result still waits in the
//   output register. If the receiver stalls, the result holds and the
//   pending lookup waits in its execute cycle, stalling the request side.
//   Synchronous reset clears all valid bits, occupancy, counters and the
//   policy register (FIFO); no clearing pass is needed.
//   The APB port holds one register, policy_lru, at byte address 0; change
//   it only while the block is idle.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_lookup #(
    parameter int TLB_ENTRIES = 32,
    parameter int PAGE_BITS   = 8,
    parameter int FRAME_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [PAGE_BITS-1:0]                 i_page,
    input  logic [FRAME_BITS-1:0]                i_fill_frame,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [FRAME_BITS-1:0]                o_frame,
    output logic                                 o_hit,
    output logic [tlbfl_pkg::COUNT_BITS-1:0]     o_lookup_count,
    output logic [tlbfl_pkg::COUNT_BITS-1:0]     o_hit_count,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tlbfl_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tlbfl_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tlbfl_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                 pready
);

    tlbfl_pkg::t_cmd cmd;
    logic            r_policy_lru;
    logic            cfg_wr;

    // register index is the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == tlbfl_pkg::REG_POLICY_LRU);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_lru <= 1'b0;
        end else if (cfg_wr) begin
            r_policy_lru <= pwdata[0];
        end
    end

    // read back the policy; unknown addresses read zero
    assign prdata = (paddr[2] == tlbfl_pkg::REG_POLICY_LRU)
                    ? tlbfl_pkg::APB_DATA_BITS'(r_policy_lru) : '0;

    tlbfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    tlbfl_dp #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_BITS   (PAGE_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_policy_lru   (r_policy_lru),
        .i_page         (i_page),
        .i_fill_frame   (i_fill_frame),
        .o_frame        (o_frame),
        .o_hit          (o_hit),
        .o_lookup_count (o_lookup_count),
        .o_hit_count    (o_hit_count)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fully associative translation buffer.
// A shadow copy of the buffer predicts every translation beat. It tracks
// entries, age ranks, occupancy, both counters and the replacement policy.
// A short directed pass covers extreme pages and frames, hits on the newest
// entry, a masked policy word and a write to an unmapped register. Random
// phases then reuse a small page pool, which forces evictions and repeat
// hits. Each phase sets a policy and a mix of sender gaps and receiver
// stalls; some phases repeat the same settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRIES      = 32;
    localparam int PAGE_W       = 8;
    localparam int FRAME_W      = 8;
    localparam int CLK_HALF     = 4;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 215;
    localparam int POOL_SPAN    = 40;   // a little above the entry count
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [tlbfl_pkg::APB_ADDR_BITS-1:0] ADDR_POLICY =
        tlbfl_pkg::APB_ADDR_BITS'(4 * int'(tlbfl_pkg::REG_POLICY_LRU));
    localparam logic [tlbfl_pkg::APB_ADDR_BITS-1:0] ADDR_UNMAPPED =
        tlbfl_pkg::APB_ADDR_BITS'(4 * (int'(tlbfl_pkg::REG_POLICY_LRU) + 1));

    typedef struct packed {
        logic [FRAME_W-1:0]               frame;
        logic                             hit;
        logic [tlbfl_pkg::COUNT_BITS-1:0] lookups;
        logic [tlbfl_pkg::COUNT_BITS-1:0] hits;
    } t_translation;

    typedef enum {
        GAPS_NONE,
        GAPS_SENDER,
        GAPS_RECEIVER,
        GAPS_BOTH
    } t_gaps;

    // Shadow of the buffer: predicts each translation and checks the
    // result beats against the queue of pending translations.
    class t_tlb_shadow;
        bit                               used[ENTRIES];
        bit [PAGE_W-1:0]                  tag[ENTRIES];
        bit [FRAME_W-1:0]                 frame_of[ENTRIES];
        int unsigned                      age[ENTRIES];
        int unsigned                      fill_level;
        bit [tlbfl_pkg::COUNT_BITS-1:0]   lookups;
        bit [tlbfl_pkg::COUNT_BITS-1:0]   hits;
        bit                               lru;
        t_translation                     pending_q[$];
        int unsigned                      errors;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            fill_level = 0;
            lookups    = '0;
            hits       = '0;
            lru        = 1'b0;
            errors     = 0;
        endfunction

        function void set_policy(bit lru_on);
            lru = lru_on;
        endfunction

        function void age_younger(int unsigned limit);
            foreach (used[i]) if (used[i] && age[i] < limit) age[i]++;
        endfunction

        function void note_request(bit [PAGE_W-1:0] page, bit [FRAME_W-1:0] fill);
            int match;
            int slot;
            t_translation t;
            match = -1;
            slot  = -1;
            lookups++;
            foreach (used[i]) if (match < 0 && used[i] && tag[i] == page) match = i;
            if (match >= 0) begin
                hits++;
                t.frame = frame_of[match];
                t.hit   = 1'b1;
                if (lru) begin
                    age_younger(age[match]);
                    age[match] = 0;
                end
            end else begin
                t.frame = fill;
                t.hit   = 1'b0;
                if (fill_level < ENTRIES) begin
                    foreach (used[i]) if (slot < 0 && !used[i]) slot = i;
                    fill_level++;
                end else begin
                    // full: the oldest rank gives up its slot
                    foreach (used[i]) if (slot < 0 || age[i] >= age[slot]) slot = i;
                    used[slot] = 1'b0;
                end
                age_younger(ENTRIES);
                used[slot]     = 1'b1;
                tag[slot]      = page;
                frame_of[slot] = fill;
                age[slot]      = 0;
            end
            t.lookups = lookups;
            t.hits    = hits;
            pending_q.push_back(t);
        endfunction

        function void report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void check_translation(logic [FRAME_W-1:0] frame, logic hit,
                                        logic [tlbfl_pkg::COUNT_BITS-1:0] lookup_count,
                                        logic [tlbfl_pkg::COUNT_BITS-1:0] hit_count);
            t_translation want;
            if (pending_q.size() == 0) begin
                report("result beat with no pending translation");
                return;
            end
            want = pending_q.pop_front();
            if (frame !== want.frame)
                report($sformatf("frame %h, expected %h", frame, want.frame));
            if (hit !== want.hit)
                report($sformatf("hit %b, expected %b", hit, want.hit));
            if (lookup_count !== want.lookups)
                report($sformatf("lookup_count %0d, expected %0d",
                                 lookup_count, want.lookups));
            if (hit_count !== want.hits)
                report($sformatf("hit_count %0d, expected %0d", hit_count, want.hits));
        endfunction
    endclass

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n;
    logic                                  i_in_valid;
    logic                                  o_in_stall;
    logic [PAGE_W-1:0]                     i_page;
    logic [FRAME_W-1:0]                    i_fill_frame;
    logic                                  o_out_valid;
    logic                                  i_out_stall;
    logic [FRAME_W-1:0]                    o_frame;
    logic                                  o_hit;
    logic [tlbfl_pkg::COUNT_BITS-1:0]      o_lookup_count;
    logic [tlbfl_pkg::COUNT_BITS-1:0]      o_hit_count;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [tlbfl_pkg::APB_ADDR_BITS-1:0]   paddr;
    logic [tlbfl_pkg::APB_DATA_BITS-1:0]   pwdata;
    logic [tlbfl_pkg::APB_DATA_BITS-1:0]   prdata;
    logic                                  pready;

    t_tlb_shadow shadow = new();

    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int calm_in       = 0;
    int calm_out      = 0;
    int cycles        = 0;

    // policy words per phase: some carry junk above bit 0, which is dropped
    logic [tlbfl_pkg::APB_DATA_BITS-1:0] phase_policy[PHASES] =
        '{32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0001, 32'h0000_0001,
          32'h0000_0000, 32'h0000_0001};
    t_gaps phase_gaps[PHASES] =
        '{GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH, GAPS_SENDER, GAPS_NONE};

    tlb_fifo_lru_lookup #(
        .TLB_ENTRIES (ENTRIES),
        .PAGE_BITS   (PAGE_W),
        .FRAME_BITS  (FRAME_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_page         (i_page),
        .i_fill_frame   (i_fill_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame        (o_frame),
        .o_hit          (o_hit),
        .o_lookup_count (o_lookup_count),
        .o_hit_count    (o_hit_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Bound the run; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sample both channels at the rising edge. Check the result beat before
    // noting the request: the beat in flight always belongs to an older one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                shadow.check_translation(o_frame, o_hit, o_lookup_count, o_hit_count);
            if (i_in_valid && !o_in_stall)
                shadow.note_request(i_page, i_fill_frame);
        end
    end

    // Receiver stalls at random; a calm stretch now and then stalls nothing.
    always @(negedge i_clk) begin
        if (calm_out > 0) begin
            calm_out--;
        end else if ($urandom_range(31) == 0) begin
            calm_out = 30;
        end
        i_out_stall <= (calm_out == 0) && ($urandom_range(99) < out_stall_pct);
    end

    // Present one request beat, idling before it at random, and hold it
    // until the block takes it.
    task automatic send_request(input logic [PAGE_W-1:0] page,
                                input logic [FRAME_W-1:0] fill);
        @(negedge i_clk);
        if (calm_in > 0) begin
            calm_in--;
        end else if ($urandom_range(15) == 0) begin
            calm_in = 24;
        end
        if (calm_in == 0) begin
            while ($urandom_range(99) < in_gap_pct) begin
                i_in_valid   <= 1'b0;
                i_page       <= PAGE_W'($urandom);
                i_fill_frame <= FRAME_W'($urandom);
                @(negedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_page       <= page;
        i_fill_frame <= fill;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid once the last beat has gone.
    task automatic end_requests();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // APB write: setup, then access; the register updates at the access edge.
    task automatic apb_write(input logic [tlbfl_pkg::APB_ADDR_BITS-1:0] addr,
                             input logic [tlbfl_pkg::APB_DATA_BITS-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_POLICY) shadow.set_policy(data[0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every pending translation has been checked, then idle.
    task automatic drain();
        while (shadow.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_gaps(input t_gaps gaps);
        case (gaps)
            GAPS_NONE: begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end
            GAPS_SENDER: begin
                in_gap_pct    = 77;
                out_stall_pct = 0;
            end
            GAPS_RECEIVER: begin
                in_gap_pct    = 0;
                out_stall_pct = 77;
            end
            default: begin
                in_gap_pct    = 6;
                out_stall_pct = 6;
            end
        endcase
    endtask

    initial begin
        int                 pick;
        int                 pool_base;
        logic [PAGE_W-1:0]  page;

        // hold every input at a known value through reset
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_page       = '0;
        i_fill_frame = '0;
        i_out_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass, FIFO order
        apb_write(ADDR_POLICY, 32'h0000_0000);
        send_request(8'h00, 8'h00);     // miss, lowest page and frame
        send_request(8'hFF, 8'hFF);     // miss, highest page and frame
        send_request(8'h00, 8'hAA);     // hit: stored frame, not the fill
        send_request(8'h55, 8'h5A);
        send_request(8'hAA, 8'hA5);
        send_request(8'hAA, 8'h00);     // hit on the newest entry
        send_request(8'hAA, 8'hFF);
        send_request(8'hFF, 8'h00);     // hit on an older entry
        send_request(8'h0F, 8'hF0);
        send_request(8'hF0, 8'h0F);
        end_requests();
        drain();

        // switch to LRU with junk above bit 0, then poke an unmapped register
        apb_write(ADDR_POLICY, 32'hFFFF_FFFF);
        apb_write(ADDR_UNMAPPED, 32'h0000_0000);
        send_request(8'h00, 8'h01);     // hit on the oldest, becomes newest
        send_request(8'h00, 8'h02);     // hit on the newest
        send_request(8'h55, 8'h00);
        send_request(8'h80, 8'h7F);
        send_request(8'h01, 8'hFE);
        send_request(8'hFF, 8'h80);
        end_requests();
        drain();

        // random phases: a pool a bit larger than the buffer keeps it full
        // and evicting, hot pages give repeated hits
        for (int phase = 0; phase < PHASES; phase++) begin
            apb_write(ADDR_POLICY, phase_policy[phase]);
            set_gaps(phase_gaps[phase]);
            pool_base = $urandom_range(256 - POOL_SPAN);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    page = PAGE_W'(pool_base + $urandom_range(POOL_SPAN - 1));
                end else if (pick < 85) begin
                    page = PAGE_W'(pool_base + $urandom_range(5));
                end else begin
                    page = PAGE_W'($urandom_range(255));
                end
                send_request(page, FRAME_W'($urandom_range(255)));
            end
            end_requests();
            drain();
        end

        set_gaps(GAPS_NONE);
        repeat (8) @(posedge i_clk);
        if (shadow.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
